[src/chull_pkg.sv]
// ============================================================================
// chull_pkg
// Shared types and constants for the convex hull core.
// ============================================================================
package chull_pkg;

    localparam int CRD_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
    } point_t;

    typedef enum logic {
        ITEM_POINT,
        ITEM_LAST
    } item_kind_t;

    typedef struct packed {
        point_t     pt;
        item_kind_t kind;
    } item_t;

    // Request to / response from the convexity unit
    typedef struct packed {
        logic   start;
        point_t p0;
        point_t p1;
        point_t p2;
    } cross_req_t;

    typedef struct packed {
        logic done;
        logic convex;
    } cross_rsp_t;

    typedef enum logic [1:0] {
        CR_IDLE,
        CR_MUL_L,
        CR_MUL_R,
        CR_CMP
    } cross_state_t;

    typedef enum logic [5:0] {
        BK_IDLE,
        BK_INS_RD,
        BK_INS_CMP,
        BK_INS_PUT0,
        BK_LOADED,
        BK_SMALL,
        BK_TOP0,
        BK_TOP_RD,
        BK_TOP_CMP,
        BK_TOP_TRIM,
        BK_S2_RD,
        BK_S2_EMIT,
        BK_BOT_RD0,
        BK_BOT0,
        BK_BOT_RD,
        BK_BOT_CMP,
        BK_BOT_TRIM,
        BK_Q_RD,
        BK_Q_GET,
        BK_Q_W1,
        BK_Q_T2,
        BK_Q_W2,
        BK_L_CHK,
        BK_L_GET,
        BK_L_W,
        BK_L_PUSH,
        BK_R_CHK,
        BK_R_GET,
        BK_R_W,
        BK_R_PUSH,
        BK_NEXT,
        BK_FIN,
        BK_CHECK,
        BK_FAIL,
        BK_RO_RD,
        BK_RO_EMIT,
        BK_LO_RD,
        BK_LO_EMIT,
        BK_CLEAR
    } back_state_t;

    // Sort order: by y, then by x (signed)
    function automatic logic pt_after(input point_t a, input point_t b);
        pt_after = ($signed(a.y) > $signed(b.y)) ||
                   ((a.y == b.y) && ($signed(a.x) > $signed(b.x)));
    endfunction

endpackage

[src/chull_front.sv]
// ============================================================================
// chull_front
// Input side: accepts point items, tags them and queues them for the back end.
// ============================================================================
module chull_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [chull_pkg::CRD_W-1:0]  point_x,
    input  logic signed [chull_pkg::CRD_W-1:0]  point_y,
    input  logic                                last_input,
    output logic                                q_valid,
    input  logic                                q_pop,
    output chull_pkg::item_t                    q_item
);

    chull_pkg::item_t              buf_reg [chull_pkg::QUEUE_DEPTH];
    logic [chull_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [chull_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [chull_pkg::QPTR_W:0]    fill_reg, fill_next;
    logic                          push;
    chull_pkg::item_t              new_item;

    // Classify the incoming item
    always_comb
    begin
        new_item.pt.x = point_x;
        new_item.pt.y = point_y;
        new_item.kind = last_input ? chull_pkg::ITEM_LAST : chull_pkg::ITEM_POINT;
    end

    assign in_ready = (fill_reg != (chull_pkg::QPTR_W+1)'(chull_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = buf_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !(q_pop && q_valid))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

[src/chull_cross.sv]
// ============================================================================
// chull_cross
// Exact strict convexity test of three points, one shared 33x33 multiplier.
// ============================================================================
module chull_cross (
    input  logic                   clk,
    input  logic                   rst_n,
    input  chull_pkg::cross_req_t  req,
    output chull_pkg::cross_rsp_t  rsp
);

    localparam int DW = chull_pkg::CRD_W + 1;
    localparam int PW = 2 * DW;

    chull_pkg::cross_state_t st_reg, st_next;
    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [PW-1:0] l_reg, r_reg;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    // Shared multiplier: left product first, then right product
    assign mul_a = (st_reg == chull_pkg::CR_MUL_L) ? a_reg : c_reg;
    assign mul_b = (st_reg == chull_pkg::CR_MUL_L) ? b_reg : d_reg;
    assign prod  = mul_a * mul_b;

    // Convex when (y1-y0)(x1-x2) > (x0-x1)(y2-y1)
    assign rsp.done   = (st_reg == chull_pkg::CR_CMP);
    assign rsp.convex = (l_reg > r_reg);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            chull_pkg::CR_IDLE:  st_next = req.start ? chull_pkg::CR_MUL_L : chull_pkg::CR_IDLE;
            chull_pkg::CR_MUL_L: st_next = chull_pkg::CR_MUL_R;
            chull_pkg::CR_MUL_R: st_next = chull_pkg::CR_CMP;
            chull_pkg::CR_CMP:   st_next = chull_pkg::CR_IDLE;
            default:             st_next = chull_pkg::CR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= chull_pkg::CR_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Differences, sign-extended by one bit
    always_ff @(posedge clk)
    begin
        if (st_reg == chull_pkg::CR_IDLE && req.start)
        begin
            a_reg <= {req.p1.y[DW-2], req.p1.y} - {req.p0.y[DW-2], req.p0.y};
            b_reg <= {req.p1.x[DW-2], req.p1.x} - {req.p2.x[DW-2], req.p2.x};
            c_reg <= {req.p0.x[DW-2], req.p0.x} - {req.p1.x[DW-2], req.p1.x};
            d_reg <= {req.p2.y[DW-2], req.p2.y} - {req.p1.y[DW-2], req.p1.y};
        end
        if (st_reg == chull_pkg::CR_MUL_L)
        begin
            l_reg <= prod;
        end
        if (st_reg == chull_pkg::CR_MUL_R)
        begin
            r_reg <= prod;
        end
    end

endmodule

[src/chull_back.sv]
// ============================================================================
// chull_back
// Sequencer: sorted point store, row trimming, chain building, hull output.
// ============================================================================
module chull_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  chull_pkg::item_t                    q_item,
    output chull_pkg::cross_req_t               cr_req,
    input  chull_pkg::cross_rsp_t               cr_rsp,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [chull_pkg::CRD_W-1:0]  hull_x,
    output logic signed [chull_pkg::CRD_W-1:0]  hull_y,
    output logic                                last_vertex,
    output logic                                hull_failed,
    output logic                                points_dropped
);

    localparam int CAP   = MAX_POINTS + 2;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CAW   = $clog2(CAP);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = $clog2(CAP + 1);
    localparam int SW    = CW + 1;

    // Memories
    chull_pkg::point_t pmem [MAX_POINTS];
    chull_pkg::point_t lmem [CAP];
    chull_pkg::point_t rmem [CAP];

    logic              p_we;
    logic [AW-1:0]     p_waddr, p_raddr;
    chull_pkg::point_t p_wdata, p_rd_reg;
    logic              l_we, r_we;
    logic [CAW-1:0]    l_waddr, r_waddr, l_ra0, l_ra1, r_ra0, r_ra1;
    chull_pkg::point_t l_wdata, r_wdata, l_rd0_reg, l_rd1_reg, r_rd0_reg, r_rd1_reg;

    // Control and working registers
    chull_pkg::back_state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    chull_pkg::point_t t_reg, t_next, a0_reg, a0_next, a1_reg, a1_next, q_reg, q_next;
    logic              last_reg, last_next, drop_reg, drop_next, ipos2_reg, ipos2_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [CW-1:0]     num_reg, num_next, numy_reg, numy_next, off_reg, off_next;
    logic [CW-1:0]     i_reg, i_next, nl_reg, nl_next, nr_reg, nr_next, idx_reg, idx_next;
    logic [SW-1:0]     k_reg, k_next;
    logic [chull_pkg::CRD_W-1:0] maxy_reg, maxy_next, miny_reg, miny_next;
    logic [chull_pkg::CRD_W-1:0] urx_reg, urx_next, ulx_reg, ulx_next, lastx_reg, lastx_next;
    logic [chull_pkg::CRD_W-1:0] dlx_reg, dlx_next, dly_reg, dly_next;
    logic [chull_pkg::CRD_W-1:0] drx_reg, drx_next, dry_reg, dry_next;

    // Output register
    logic              out_valid_reg;
    chull_pkg::point_t out_pt_reg;
    logic              out_last_reg, out_fail_reg, out_drop_reg;
    logic              emit_valid, emit_last, emit_fail, emit_ok;
    chull_pkg::point_t emit_pt;

    // Helpers
    logic [CW-1:0]     top_ndel, bot_ndel, cnt_ext;
    logic              bot_eq;
    logic [SW-1:0]     total;

    assign cnt_ext  = CW'(cnt_reg);
    assign top_ndel = numy_reg - CW'(2) + CW'(lastx_reg == urx_reg);
    assign bot_eq   = (dlx_reg == lastx_reg);
    assign bot_ndel = numy_reg - CW'(2) + CW'(bot_eq);
    assign total    = SW'(nr_reg) + SW'(nl_reg) - SW'(!ipos2_reg);
    assign emit_ok  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign hull_x         = out_pt_reg.x;
    assign hull_y         = out_pt_reg.y;
    assign last_vertex    = out_last_reg;
    assign hull_failed    = out_fail_reg;
    assign points_dropped = out_drop_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        t_next     = t_reg;
        a0_next    = a0_reg;
        a1_next    = a1_reg;
        q_next     = q_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        ipos2_next = ipos2_reg;
        j_next     = j_reg;
        num_next   = num_reg;
        numy_next  = numy_reg;
        off_next   = off_reg;
        i_next     = i_reg;
        nl_next    = nl_reg;
        nr_next    = nr_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        maxy_next  = maxy_reg;
        miny_next  = miny_reg;
        urx_next   = urx_reg;
        ulx_next   = ulx_reg;
        lastx_next = lastx_reg;
        dlx_next   = dlx_reg;
        dly_next   = dly_reg;
        drx_next   = drx_reg;
        dry_next   = dry_reg;

        q_pop      = 1'b0;
        p_we       = 1'b0;
        p_waddr    = '0;
        p_wdata    = t_reg;
        p_raddr    = '0;
        l_we       = 1'b0;
        l_waddr    = nl_reg[CAW-1:0];
        l_wdata    = q_reg;
        r_we       = 1'b0;
        r_waddr    = nr_reg[CAW-1:0];
        r_wdata    = q_reg;
        l_ra0      = '0;
        l_ra1      = '0;
        r_ra0      = '0;
        r_ra1      = '0;
        cr_req     = '0;
        emit_valid = 1'b0;
        emit_pt    = '0;
        emit_last  = 1'b0;
        emit_fail  = 1'b0;

        case (state_reg)
            // Take one item and insert it in sorted position
            chull_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    t_next    = q_item.pt;
                    last_next = (q_item.kind == chull_pkg::ITEM_LAST);
                    if (cnt_ext == CW'(MAX_POINTS))
                    begin
                        ovf_next   = 1'b1;
                        state_next = chull_pkg::BK_LOADED;
                    end
                    else if (cnt_reg == '0)
                    begin
                        a0_next    = q_item.pt;
                        p_we       = 1'b1;
                        p_waddr    = '0;
                        p_wdata    = q_item.pt;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = chull_pkg::BK_LOADED;
                    end
                    else
                    begin
                        if (cnt_reg == CNT_W'(1))
                        begin
                            a1_next = q_item.pt;
                        end
                        j_next     = AW'(cnt_reg - 1'b1);
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = chull_pkg::BK_INS_RD;
                    end
                end
            end
            chull_pkg::BK_INS_RD:
            begin
                p_raddr    = j_reg;
                state_next = chull_pkg::BK_INS_CMP;
            end
            chull_pkg::BK_INS_CMP:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg + 1'b1;
                if (chull_pkg::pt_after(p_rd_reg, t_reg))
                begin
                    p_wdata = p_rd_reg;
                    if (j_reg == '0)
                    begin
                        state_next = chull_pkg::BK_INS_PUT0;
                    end
                    else
                    begin
                        j_next     = j_reg - 1'b1;
                        state_next = chull_pkg::BK_INS_RD;
                    end
                end
                else
                begin
                    p_wdata    = t_reg;
                    state_next = chull_pkg::BK_LOADED;
                end
            end
            chull_pkg::BK_INS_PUT0:
            begin
                p_we       = 1'b1;
                p_waddr    = '0;
                p_wdata    = t_reg;
                state_next = chull_pkg::BK_LOADED;
            end
            // Closing item starts the hull
            chull_pkg::BK_LOADED:
            begin
                p_raddr = AW'(cnt_reg - 1'b1);
                if (!last_reg)
                begin
                    state_next = chull_pkg::BK_IDLE;
                end
                else
                begin
                    num_next  = cnt_ext;
                    drop_next = ovf_reg;
                    k_next    = '0;
                    state_next = (cnt_ext <= CW'(2)) ? chull_pkg::BK_SMALL
                                                     : chull_pkg::BK_TOP0;
                end
            end
            // One or two points, arrival order, identical pair merged
            chull_pkg::BK_SMALL:
            begin
                emit_valid = 1'b1;
                emit_pt    = (k_reg == '0) ? a0_reg : a1_reg;
                emit_last  = (k_reg != '0) || (num_reg == CW'(1)) || (a0_reg == a1_reg);
                if (emit_ok)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = emit_last ? chull_pkg::BK_CLEAR : chull_pkg::BK_SMALL;
                end
            end
            // Top row
            chull_pkg::BK_TOP0:
            begin
                maxy_next  = p_rd_reg.y;
                urx_next   = p_rd_reg.x;
                lastx_next = p_rd_reg.x;
                numy_next  = CW'(1);
                state_next = chull_pkg::BK_TOP_RD;
            end
            chull_pkg::BK_TOP_RD:
            begin
                p_raddr    = AW'(num_reg - numy_reg - 1'b1);
                state_next = chull_pkg::BK_TOP_CMP;
            end
            chull_pkg::BK_TOP_CMP:
            begin
                state_next = chull_pkg::BK_TOP_TRIM;
                if (p_rd_reg.y == maxy_reg)
                begin
                    numy_next  = numy_reg + 1'b1;
                    lastx_next = p_rd_reg.x;
                    if (numy_reg + 1'b1 < num_reg)
                    begin
                        state_next = chull_pkg::BK_TOP_RD;
                    end
                end
            end
            chull_pkg::BK_TOP_TRIM:
            begin
                ulx_next = lastx_reg;
                num_next = num_reg;
                if (numy_reg >= CW'(2) && top_ndel != '0)
                begin
                    p_we     = 1'b1;
                    p_waddr  = AW'(num_reg - 1'b1 - top_ndel);
                    p_wdata  = '{x: urx_reg, y: maxy_reg};
                    num_next = num_reg - top_ndel;
                end
                k_next     = '0;
                state_next = (num_next <= CW'(2)) ? chull_pkg::BK_S2_RD
                                                  : chull_pkg::BK_BOT_RD0;
            end
            // Trimmed set down to one or two points, sorted order
            chull_pkg::BK_S2_RD:
            begin
                p_raddr    = AW'(k_reg);
                state_next = chull_pkg::BK_S2_EMIT;
            end
            chull_pkg::BK_S2_EMIT:
            begin
                p_raddr    = AW'(k_reg);
                emit_valid = 1'b1;
                emit_pt    = p_rd_reg;
                emit_last  = (k_reg == SW'(num_reg) - 1'b1);
                if (emit_ok)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = emit_last ? chull_pkg::BK_CLEAR : chull_pkg::BK_S2_RD;
                end
            end
            // Bottom row
            chull_pkg::BK_BOT_RD0:
            begin
                p_raddr    = '0;
                state_next = chull_pkg::BK_BOT0;
            end
            chull_pkg::BK_BOT0:
            begin
                miny_next  = p_rd_reg.y;
                dlx_next   = p_rd_reg.x;
                drx_next   = p_rd_reg.x;
                lastx_next = p_rd_reg.x;
                numy_next  = CW'(1);
                state_next = chull_pkg::BK_BOT_RD;
            end
            chull_pkg::BK_BOT_RD:
            begin
                p_raddr    = AW'(numy_reg);
                state_next = chull_pkg::BK_BOT_CMP;
            end
            chull_pkg::BK_BOT_CMP:
            begin
                state_next = chull_pkg::BK_BOT_TRIM;
                if (p_rd_reg.y == miny_reg)
                begin
                    numy_next  = numy_reg + 1'b1;
                    lastx_next = p_rd_reg.x;
                    if (numy_reg + 1'b1 < num_reg)
                    begin
                        state_next = chull_pkg::BK_BOT_RD;
                    end
                end
            end
            chull_pkg::BK_BOT_TRIM:
            begin
                ipos2_next = 1'b0;
                off_next   = '0;
                num_next   = num_reg;
                if (numy_reg >= CW'(2))
                begin
                    drx_next   = lastx_reg;
                    ipos2_next = !bot_eq;
                    off_next   = bot_ndel;
                    num_next   = num_reg - bot_ndel;
                end
                l_we       = 1'b1;
                l_waddr    = '0;
                l_wdata    = '{x: dlx_reg, y: miny_reg};
                r_we       = 1'b1;
                r_waddr    = '0;
                r_wdata    = '{x: (ipos2_next ? lastx_reg : dlx_reg), y: miny_reg};
                nl_next    = CW'(1);
                nr_next    = CW'(1);
                dly_next   = miny_reg;
                dry_next   = miny_reg;
                i_next     = ipos2_next ? CW'(2) : CW'(1);
                state_next = (i_next < num_next) ? chull_pkg::BK_Q_RD : chull_pkg::BK_FIN;
            end
            // Chain building, one point at a time
            chull_pkg::BK_Q_RD:
            begin
                p_raddr    = AW'(i_reg + off_reg);
                state_next = chull_pkg::BK_Q_GET;
            end
            chull_pkg::BK_Q_GET:
            begin
                q_next       = p_rd_reg;
                cr_req.start = 1'b1;
                cr_req.p0    = '{x: ulx_reg, y: maxy_reg};
                cr_req.p1    = p_rd_reg;
                cr_req.p2    = '{x: dlx_reg, y: dly_reg};
                state_next   = chull_pkg::BK_Q_W1;
            end
            chull_pkg::BK_Q_W1:
            begin
                if (cr_rsp.done)
                begin
                    state_next = cr_rsp.convex ? chull_pkg::BK_L_CHK : chull_pkg::BK_Q_T2;
                end
            end
            chull_pkg::BK_Q_T2:
            begin
                cr_req.start = 1'b1;
                cr_req.p0    = '{x: drx_reg, y: dry_reg};
                cr_req.p1    = q_reg;
                cr_req.p2    = '{x: urx_reg, y: maxy_reg};
                state_next   = chull_pkg::BK_Q_W2;
            end
            chull_pkg::BK_Q_W2:
            begin
                if (cr_rsp.done)
                begin
                    state_next = cr_rsp.convex ? chull_pkg::BK_R_CHK : chull_pkg::BK_NEXT;
                end
            end
            // Left chain: pop while not convex, then push
            chull_pkg::BK_L_CHK:
            begin
                l_ra0      = CAW'(nl_reg - 1'b1);
                l_ra1      = CAW'(nl_reg - CW'(2));
                state_next = (nl_reg > CW'(1)) ? chull_pkg::BK_L_GET : chull_pkg::BK_L_PUSH;
            end
            chull_pkg::BK_L_GET:
            begin
                cr_req.start = 1'b1;
                cr_req.p0    = q_reg;
                cr_req.p1    = l_rd0_reg;
                cr_req.p2    = l_rd1_reg;
                state_next   = chull_pkg::BK_L_W;
            end
            chull_pkg::BK_L_W:
            begin
                if (cr_rsp.done)
                begin
                    if (cr_rsp.convex)
                    begin
                        state_next = chull_pkg::BK_L_PUSH;
                    end
                    else
                    begin
                        nl_next    = nl_reg - 1'b1;
                        state_next = chull_pkg::BK_L_CHK;
                    end
                end
            end
            chull_pkg::BK_L_PUSH:
            begin
                if (nl_reg < CW'(CAP))
                begin
                    l_we    = 1'b1;
                    nl_next = nl_reg + 1'b1;
                end
                dlx_next   = q_reg.x;
                dly_next   = q_reg.y;
                state_next = chull_pkg::BK_NEXT;
            end
            // Right chain: pop while not convex, then push
            chull_pkg::BK_R_CHK:
            begin
                r_ra0      = CAW'(nr_reg - 1'b1);
                r_ra1      = CAW'(nr_reg - CW'(2));
                state_next = (nr_reg > CW'(1)) ? chull_pkg::BK_R_GET : chull_pkg::BK_R_PUSH;
            end
            chull_pkg::BK_R_GET:
            begin
                cr_req.start = 1'b1;
                cr_req.p0    = r_rd1_reg;
                cr_req.p1    = r_rd0_reg;
                cr_req.p2    = q_reg;
                state_next   = chull_pkg::BK_R_W;
            end
            chull_pkg::BK_R_W:
            begin
                if (cr_rsp.done)
                begin
                    if (cr_rsp.convex)
                    begin
                        state_next = chull_pkg::BK_R_PUSH;
                    end
                    else
                    begin
                        nr_next    = nr_reg - 1'b1;
                        state_next = chull_pkg::BK_R_CHK;
                    end
                end
            end
            chull_pkg::BK_R_PUSH:
            begin
                if (nr_reg < CW'(CAP))
                begin
                    r_we    = 1'b1;
                    nr_next = nr_reg + 1'b1;
                end
                drx_next   = q_reg.x;
                dry_next   = q_reg.y;
                state_next = chull_pkg::BK_NEXT;
            end
            chull_pkg::BK_NEXT:
            begin
                if (i_reg + 1'b1 < num_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = chull_pkg::BK_Q_RD;
                end
                else
                begin
                    state_next = chull_pkg::BK_FIN;
                end
            end
            // Close both chains with the top row ends
            chull_pkg::BK_FIN:
            begin
                if (nl_reg < CW'(CAP))
                begin
                    l_we    = 1'b1;
                    l_wdata = '{x: ulx_reg, y: maxy_reg};
                    nl_next = nl_reg + 1'b1;
                end
                if ($signed(urx_reg) > $signed(ulx_reg) && nr_reg < CW'(CAP))
                begin
                    r_we    = 1'b1;
                    r_wdata = '{x: urx_reg, y: maxy_reg};
                    nr_next = nr_reg + 1'b1;
                end
                state_next = chull_pkg::BK_CHECK;
            end
            chull_pkg::BK_CHECK:
            begin
                k_next   = '0;
                idx_next = '0;
                if (total > SW'(num_reg) || total == '0)
                begin
                    state_next = chull_pkg::BK_FAIL;
                end
                else
                begin
                    state_next = chull_pkg::BK_RO_RD;
                end
            end
            chull_pkg::BK_FAIL:
            begin
                emit_valid = 1'b1;
                emit_last  = 1'b1;
                emit_fail  = 1'b1;
                if (emit_ok)
                begin
                    state_next = chull_pkg::BK_CLEAR;
                end
            end
            // Right chain upward
            chull_pkg::BK_RO_RD:
            begin
                r_ra0      = CAW'(idx_reg);
                state_next = chull_pkg::BK_RO_EMIT;
            end
            chull_pkg::BK_RO_EMIT:
            begin
                r_ra0      = CAW'(idx_reg);
                emit_valid = 1'b1;
                emit_pt    = r_rd0_reg;
                emit_last  = (k_reg == total - 1'b1);
                if (emit_ok)
                begin
                    k_next = k_reg + 1'b1;
                    if (emit_last)
                    begin
                        state_next = chull_pkg::BK_CLEAR;
                    end
                    else if (idx_reg + 1'b1 < nr_reg)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = chull_pkg::BK_RO_RD;
                    end
                    else
                    begin
                        idx_next   = nl_reg - 1'b1;
                        state_next = chull_pkg::BK_LO_RD;
                    end
                end
            end
            // Left chain downward
            chull_pkg::BK_LO_RD:
            begin
                l_ra0      = CAW'(idx_reg);
                state_next = chull_pkg::BK_LO_EMIT;
            end
            chull_pkg::BK_LO_EMIT:
            begin
                l_ra0      = CAW'(idx_reg);
                emit_valid = 1'b1;
                emit_pt    = l_rd0_reg;
                emit_last  = (k_reg == total - 1'b1);
                if (emit_ok)
                begin
                    k_next   = k_reg + 1'b1;
                    idx_next = idx_reg - 1'b1;
                    state_next = emit_last ? chull_pkg::BK_CLEAR : chull_pkg::BK_LO_RD;
                end
            end
            chull_pkg::BK_CLEAR:
            begin
                cnt_next   = '0;
                ovf_next   = 1'b0;
                state_next = chull_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = chull_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chull_pkg::BK_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            if (emit_valid && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        a0_reg    <= a0_next;
        a1_reg    <= a1_next;
        q_reg     <= q_next;
        last_reg  <= last_next;
        drop_reg  <= drop_next;
        ipos2_reg <= ipos2_next;
        j_reg     <= j_next;
        num_reg   <= num_next;
        numy_reg  <= numy_next;
        off_reg   <= off_next;
        i_reg     <= i_next;
        nl_reg    <= nl_next;
        nr_reg    <= nr_next;
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        maxy_reg  <= maxy_next;
        miny_reg  <= miny_next;
        urx_reg   <= urx_next;
        ulx_reg   <= ulx_next;
        lastx_reg <= lastx_next;
        dlx_reg   <= dlx_next;
        dly_reg   <= dly_next;
        drx_reg   <= drx_next;
        dry_reg   <= dry_next;
        if (emit_valid && emit_ok)
        begin
            out_pt_reg   <= emit_pt;
            out_last_reg <= emit_last;
            out_fail_reg <= emit_fail;
            out_drop_reg <= drop_reg;
        end
    end

    // Point store
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        p_rd_reg <= pmem[p_raddr];
    end

    // Chain stores
    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            lmem[l_waddr] <= l_wdata;
        end
        if (r_we)
        begin
            rmem[r_waddr] <= r_wdata;
        end
        l_rd0_reg <= lmem[l_ra0];
        l_rd1_reg <= lmem[l_ra1];
        r_rd0_reg <= rmem[r_ra0];
        r_rd1_reg <= rmem[r_ra1];
    end

endmodule

[src/convex_hull_monotone_chain_core.sv]
// ============================================================================
// convex_hull_monotone_chain_core
// Convex hull of a set of integer points, output counter-clockwise.
// ============================================================================
// Points enter one item each; the item with last_input set closes the set and
// the hull vertices then leave one item each, right chain upward and left
// chain downward, the final one marked last_vertex. Each point is inserted in
// y-then-x order as it arrives, moving each stored point that lies after it
// up by one place. After the closing item the top and bottom rows are trimmed,
// and the chain pass tests each point with the convexity unit, which has one
// shared multiplier, popping chain vertices that fail the test. A four-item
// input queue lets points keep arriving while the previous set is still being
// worked on. Up to MAX_POINTS points are kept per set; more are dropped and
// points_dropped is raised on that set's results.
module convex_hull_monotone_chain_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [chull_pkg::CRD_W-1:0]  point_x,
    input  logic signed [chull_pkg::CRD_W-1:0]  point_y,
    input  logic                                last_input,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [chull_pkg::CRD_W-1:0]  hull_x,
    output logic signed [chull_pkg::CRD_W-1:0]  hull_y,
    output logic                                last_vertex,
    output logic                                hull_failed,
    output logic                                points_dropped
);

    logic                  q_valid;
    logic                  q_pop;
    chull_pkg::item_t      q_item;
    chull_pkg::cross_req_t cr_req;
    chull_pkg::cross_rsp_t cr_rsp;

    chull_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_input (last_input),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    chull_cross u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cr_req),
        .rsp   (cr_rsp)
    );

    chull_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .cr_req         (cr_req),
        .cr_rsp         (cr_rsp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hull_x         (hull_x),
        .hull_y         (hull_y),
        .last_vertex    (last_vertex),
        .hull_failed    (hull_failed),
        .points_dropped (points_dropped)
    );

endmodule

[src/chull_checker.sv]
// ============================================================================
// chull_checker
// Port-level checks for the convex hull core, bound to the top level.
// ============================================================================
module chull_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [chull_pkg::CRD_W-1:0]  hull_x,
    input  logic signed [chull_pkg::CRD_W-1:0]  hull_y,
    input  logic                                last_vertex,
    input  logic                                hull_failed,
    input  logic                                points_dropped
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hull_x) && $stable(hull_y)
            && $stable(last_vertex))
        else $error("result changed while stalled");

    // A failure is a lone, zeroed, final result
    a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hull_failed |-> last_vertex && hull_x == '0 && hull_y == '0)
        else $error("failed result malformed");

    // The drop flag is the same for all vertices of one set
    a_drop_const: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_vertex |=> points_dropped == $past(points_dropped))
        else $error("drop flag changed within a set");

endmodule

bind convex_hull_monotone_chain_core chull_checker u_chull_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hull_x         (hull_x),
    .hull_y         (hull_y),
    .last_vertex    (last_vertex),
    .hull_failed    (hull_failed),
    .points_dropped (points_dropped)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: convex hull core testbench
// Sends point sets over the input channel and checks every hull vertex
// against an in-bench monotone chain hull calculation, with random idle
// cycles on the input channel and random backpressure on the output channel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_PTS   = 64;
    localparam int CHAIN_MAX = MAX_PTS + 2;
    localparam int WD_LIMIT  = 50000;
    localparam int HOLD_LEN  = 600;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic        fail;
        logic        drop;
    } vertex_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        last_input;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] hull_x;
    logic signed [31:0] hull_y;
    logic        last_vertex;
    logic        hull_failed;
    logic        points_dropped;

    // set being collected by the hull calculation
    longint set_x [MAX_PTS];
    longint set_y [MAX_PTS];
    int     set_cnt;
    bit     set_ovf;

    vertex_t hull_q[$];
    int      errors;
    int      tx_idle;
    int      rx_idle;
    int      hold_req;
    int      hold_seen;
    int      hold_cycles;
    int      quiet_cycles;

    convex_hull_monotone_chain_core #(.MAX_POINTS(MAX_PTS)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .last_input     (last_input),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hull_x         (hull_x),
        .hull_y         (hull_y),
        .last_vertex    (last_vertex),
        .hull_failed    (hull_failed),
        .points_dropped (points_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // strict left turn p0 -> p1 -> p2, exact
    function automatic bit is_convex(longint x0, longint y0, longint x1, longint y1,
                                     longint x2, longint y2);
        logic signed [79:0] lhs;
        logic signed [79:0] rhs;
        lhs = 80'(y1 - y0) * 80'(x1 - x2);
        rhs = 80'(x0 - x1) * 80'(y2 - y1);
        return lhs > rhs;
    endfunction

    task automatic push_vertex(longint x, longint y, bit last, bit fail, bit drop);
        vertex_t v;
        v.x = x[31:0];
        v.y = y[31:0];
        v.last = last;
        v.fail = fail;
        v.drop = drop;
        hull_q.push_back(v);
    endtask

    // hull of the collected set, vertices appended to hull_q
    task automatic compute_hull(bit drop);
        longint px [MAX_PTS];
        longint py [MAX_PTS];
        longint lx [CHAIN_MAX];
        longint ly [CHAIN_MAX];
        longint rx [CHAIN_MAX];
        longint ry [CHAIN_MAX];
        longint tx, ty, miny, maxy, ulx, urx, dlx, drx, dly, dry;
        int num, i, j, nl, nr, ipos0, numy, ndel, skip, total, k;
        num = set_cnt;
        for (i = 0; i < num; i++)
        begin
            px[i] = set_x[i];
            py[i] = set_y[i];
        end
        if (num <= 2)
        begin
            if (num == 2 && px[0] == px[1] && py[0] == py[1])
                num = 1;
            for (i = 0; i < num; i++)
                push_vertex(px[i], py[i], i == num - 1, 1'b0, drop);
            return;
        end
        // insertion sort by y then x
        for (i = 1; i < num; i++)
        begin
            tx = px[i];
            ty = py[i];
            j = i - 1;
            while (j >= 0 && (py[j] > ty || (py[j] == ty && px[j] > tx)))
            begin
                px[j + 1] = px[j];
                py[j + 1] = py[j];
                j--;
            end
            px[j + 1] = tx;
            py[j + 1] = ty;
        end
        miny = py[0];
        maxy = py[num - 1];
        // top row trim
        numy = 1;
        ulx = px[num - 1];
        urx = ulx;
        while (numy < num && py[num - numy - 1] == maxy)
            numy++;
        if (numy >= 2)
        begin
            ndel = numy - 2;
            ulx = px[num - numy];
            if (ulx == urx)
                ndel++;
            if (ndel > 0)
            begin
                px[num - 1 - ndel] = px[num - 1];
                py[num - 1 - ndel] = py[num - 1];
                num -= ndel;
            end
        end
        if (num <= 2)
        begin
            for (i = 0; i < num; i++)
                push_vertex(px[i], py[i], i == num - 1, 1'b0, drop);
            return;
        end
        // bottom row trim
        numy = 1;
        dlx = px[0];
        drx = dlx;
        while (numy < num && py[numy] == miny)
            numy++;
        ipos0 = 1;
        if (numy >= 2)
        begin
            ndel = numy - 2;
            drx = px[numy - 1];
            if (dlx == drx)
                ndel++;
            else
                ipos0 = 2;
            if (ndel > 0)
            begin
                for (i = 1; i < num - ndel; i++)
                begin
                    px[i] = px[i + ndel];
                    py[i] = py[i + ndel];
                end
                num -= ndel;
            end
        end
        // chain pass
        lx[0] = px[0];
        ly[0] = py[0];
        nl = 1;
        rx[0] = px[ipos0 - 1];
        ry[0] = py[ipos0 - 1];
        nr = 1;
        dly = miny;
        dry = miny;
        for (i = ipos0; i < num; i++)
        begin
            if (is_convex(ulx, maxy, px[i], py[i], dlx, dly))
            begin
                while (nl > 1 && !is_convex(px[i], py[i], lx[nl-1], ly[nl-1],
                                            lx[nl-2], ly[nl-2]))
                    nl--;
                if (nl < CHAIN_MAX)
                begin
                    lx[nl] = px[i];
                    ly[nl] = py[i];
                    nl++;
                end
                dlx = px[i];
                dly = py[i];
            end
            else if (is_convex(drx, dry, px[i], py[i], urx, maxy))
            begin
                while (nr > 1 && !is_convex(rx[nr-2], ry[nr-2], rx[nr-1], ry[nr-1],
                                            px[i], py[i]))
                    nr--;
                if (nr < CHAIN_MAX)
                begin
                    rx[nr] = px[i];
                    ry[nr] = py[i];
                    nr++;
                end
                drx = px[i];
                dry = py[i];
            end
        end
        if (nl < CHAIN_MAX)
        begin
            lx[nl] = ulx;
            ly[nl] = maxy;
            nl++;
        end
        if (urx > ulx && nr < CHAIN_MAX)
        begin
            rx[nr] = urx;
            ry[nr] = maxy;
            nr++;
        end
        skip = (ipos0 == 1) ? 1 : 0;
        total = nr + nl - skip;
        if (total > num || total < 1)
        begin
            push_vertex(0, 0, 1'b1, 1'b1, drop);
            return;
        end
        k = 0;
        for (i = 0; i < nr; i++)
        begin
            push_vertex(rx[i], ry[i], k == total - 1, 1'b0, drop);
            k++;
        end
        for (i = nl - 1; i >= skip; i--)
        begin
            push_vertex(lx[i], ly[i], k == total - 1, 1'b0, drop);
            k++;
        end
    endtask

    // one point item accepted by the core
    task automatic accept_point(logic [31:0] x, logic [31:0] y, bit last);
        if (set_cnt < MAX_PTS)
        begin
            set_x[set_cnt] = longint'($signed(x));
            set_y[set_cnt] = longint'($signed(y));
            set_cnt++;
        end
        else
            set_ovf = 1'b1;
        if (last)
        begin
            compute_hull(set_ovf);
            set_cnt = 0;
            set_ovf = 1'b0;
        end
    endtask

    // send one point item, with random idle cycles ahead of it
    task automatic send_point(logic [31:0] x, logic [31:0] y, bit last);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        last_input <= last;
        do
            @(posedge clk);
        while (!in_ready);
        accept_point(x, y, last);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 16)) - 8);
            1: return $urandom();
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    // a set of n random points, the final one marked last
    task automatic send_random_set(int n, int mode);
        int i;
        for (i = 0; i < n; i++)
            send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    task automatic test_small_sets();
        send_point(32'sd5, -32'sd3, 1'b1);
        send_point(32'sd7, 32'sd7, 1'b0);
        send_point(32'sd7, 32'sd7, 1'b1);
        send_point(32'sd7, 32'sd1, 1'b0);
        send_point(32'sd7, 32'sd2, 1'b1);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    endtask

    task automatic test_shapes();
        // collinear on a diagonal
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sd2, 32'sd2, 1'b0);
        send_point(32'sd1, 32'sd1, 1'b1);
        // square with interior point and duplicate rows
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(32'sd4, 32'sd0, 1'b0);
        send_point(32'sd2, 32'sd0, 1'b0);
        send_point(32'sd2, 32'sd2, 1'b0);
        send_point(32'sd0, 32'sd4, 1'b0);
        send_point(32'sd4, 32'sd4, 1'b0);
        send_point(32'sd1, 32'sd4, 1'b1);
        // extreme triangle
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h7fff_ffff, 1'b1);
        // all points identical
        send_point(32'sd3, 32'sd3, 1'b0);
        send_point(32'sd3, 32'sd3, 1'b0);
        send_point(32'sd3, 32'sd3, 1'b1);
    endtask

    task automatic test_overflow();
        send_random_set(MAX_PTS + 3, 0);
    endtask

    task automatic test_random(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            send_random_set(n, ($urandom_range(0, 3) == 0) ? 1 :
                               ($urandom_range(0, 9) == 0) ? 2 : 0);
            sent += n;
        end
    endtask

    // receiver stalls long while sets keep coming
    task automatic test_backpressure();
        hold_req++;
        send_random_set(20, 1);
        send_random_set(6, 0);
    endtask

    // receiver side ready, with a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            hold_seen   <= 0;
            hold_cycles <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen   <= hold_req;
            hold_cycles <= HOLD_LEN;
            out_ready   <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    // vertex checker
    always @(posedge clk)
    begin
        vertex_t v;
        if (rst_n && out_valid && out_ready)
        begin
            if (hull_q.size() == 0)
            begin
                $display("%0t: unexpected vertex x=%h y=%h", $time, hull_x, hull_y);
                errors++;
            end
            else
            begin
                v = hull_q.pop_front();
                if (hull_x !== v.x)
                begin
                    $display("%0t: hull_x exp %h got %h", $time, v.x, hull_x);
                    errors++;
                end
                if (hull_y !== v.y)
                begin
                    $display("%0t: hull_y exp %h got %h", $time, v.y, hull_y);
                    errors++;
                end
                if (last_vertex !== v.last)
                begin
                    $display("%0t: last_vertex exp %b got %b", $time, v.last, last_vertex);
                    errors++;
                end
                if (hull_failed !== v.fail)
                begin
                    $display("%0t: hull_failed exp %b got %b", $time, v.fail, hull_failed);
                    errors++;
                end
                if (points_dropped !== v.drop)
                begin
                    $display("%0t: points_dropped exp %b got %b", $time, v.drop,
                             points_dropped);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int wait_cnt;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        point_x      = '0;
        point_y      = '0;
        last_input   = 1'b0;
        set_cnt      = 0;
        set_ovf      = 1'b0;
        hold_req     = 0;
        tx_idle      = 36;
        rx_idle      = 81;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_sets();
        test_shapes();
        test_random(45);
        tx_idle = 81;
        rx_idle = 36;
        test_overflow();
        test_random(45);
        tx_idle = 0;
        rx_idle = 0;
        test_backpressure();
        test_random(45);
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (hull_q.size() != 0 && wait_cnt < WD_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && hull_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
